// ===== hw/rtl/bsem_pkg.sv =====
`timescale 1ns / 1ps
// shared types and codes for the binary semaphore table
// no dependencies

package bsem_pkg;

   localparam int OP_W     = 2;
   localparam int SEM_W    = 4;
   localparam int REQ_W    = 8;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 3;
   localparam int WAKE_W   = 8;
   // sem_id can only name this many semaphores
   localparam int SEM_REACH = 1 << SEM_W;

   typedef enum logic [OP_W-1:0] {
      OP_GET    = 2'd0,
      OP_FREE   = 2'd1,
      OP_WAIT   = 2'd2,
      OP_SIGNAL = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_BLOCK      = 3'd1,
      ST_BAD_MODE   = 3'd2,
      ST_NO_FREE    = 3'd3,
      ST_QUEUE_FULL = 3'd4,
      ST_NOT_HELD   = 3'd5
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic load;    // capture the accepted transaction, read the ring head
      logic commit;  // update the table and load the result register
   } cmd_type;

endpackage

// ===== hw/rtl/bsem_ifs.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces for requests and results
// depends on bsem_pkg

interface bsem_req_if;
   logic                          valid;
   logic                          ready;
   logic [bsem_pkg::OP_W-1:0]     op;
   logic [bsem_pkg::SEM_W-1:0]    sem_id;
   logic [bsem_pkg::REQ_W-1:0]    requester;
   logic [bsem_pkg::MODE_W-1:0]   mode;

   modport source (output valid, op, sem_id, requester, mode, input ready);
   modport sink   (input valid, op, sem_id, requester, mode, output ready);
endinterface

interface bsem_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bsem_pkg::STATUS_W-1:0]  status;
   logic [bsem_pkg::SEM_W-1:0]     granted_id;
   logic                           wake_valid;
   logic [bsem_pkg::WAKE_W-1:0]    wake_id;

   modport source (output valid, status, granted_id, wake_valid, wake_id, input ready);
   modport sink   (input valid, status, granted_id, wake_valid, wake_id, output ready);
endinterface

// ===== hw/rtl/bsem_ctrl.sv =====
`timescale 1ns / 1ps
// sequencing fsm: accept, execute, result register handshake
// depends on bsem_pkg

module bsem_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bsem_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   // result register can take a new result this cycle
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign cmd.load   = req_valid && req_ready;
   assign cmd.commit = (state_ff == S_EXEC) && slot_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.load) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (slot_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/bsem_dpath.sv =====
`timescale 1ns / 1ps
// semaphore table, per-semaphore wait rings and result register
// depends on bsem_pkg

module bsem_dpath #(
   parameter int NUM_SEMS    = 16,
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bsem_pkg::cmd_type               cmd,
   input  logic [bsem_pkg::OP_W-1:0]       req_op,
   input  logic [bsem_pkg::SEM_W-1:0]      req_sem_id,
   input  logic [bsem_pkg::REQ_W-1:0]      req_requester,
   input  logic [bsem_pkg::MODE_W-1:0]     req_mode,
   output logic [bsem_pkg::STATUS_W-1:0]   rsp_status,
   output logic [bsem_pkg::SEM_W-1:0]      rsp_granted_id,
   output logic                            rsp_wake_valid,
   output logic [bsem_pkg::WAKE_W-1:0]     rsp_wake_id
);

   // only indices reachable through sem_id get storage
   localparam int SEMS_USED = (NUM_SEMS < bsem_pkg::SEM_REACH) ? NUM_SEMS
                                                                 : bsem_pkg::SEM_REACH;
   localparam int SIW       = $clog2(SEMS_USED);
   localparam int PW        = $clog2(QUEUE_DEPTH);
   localparam int CW        = $clog2(QUEUE_DEPTH + 1);
   localparam int EW        = (ID_BITS < bsem_pkg::REQ_W) ? ID_BITS : bsem_pkg::REQ_W;
   localparam int MEM_DEPTH = 1 << (SIW + PW);

   // semaphore table
   logic           in_use_ff [SEMS_USED];
   logic           held_ff   [SEMS_USED];
   logic [PW-1:0]  head_ff   [SEMS_USED];
   logic [CW-1:0]  count_ff  [SEMS_USED];

   // wait rings, one row of QUEUE_DEPTH slots per semaphore
   logic [EW-1:0]  ring_mem  [MEM_DEPTH];
   logic [EW-1:0]  rdata_ff;

   // captured transaction
   bsem_pkg::op_type            op_ff;
   logic [SIW-1:0]              sidx_ff;
   logic                        valid_ff;
   logic [EW-1:0]               req_ff;
   logic [bsem_pkg::MODE_W-1:0] mode_ff;

   // result register
   logic [bsem_pkg::STATUS_W-1:0] status_ff;
   logic [bsem_pkg::SEM_W-1:0]    granted_ff;
   logic                          wake_valid_ff;
   logic [bsem_pkg::WAKE_W-1:0]   wake_id_ff;

   logic                  in_range;
   logic [SIW-1:0]        rd_sidx;

   logic                  cur_in_use, cur_held;
   logic [PW-1:0]         cur_head;
   logic [CW-1:0]         cur_count;
   logic                  free_found;
   logic [SIW-1:0]        free_idx;
   logic [CW:0]           tail_sum;
   logic [PW-1:0]         tail;
   logic [PW:0]           head_inc;
   logic [PW-1:0]         head_next;

   bsem_pkg::status_type          status_in;
   logic [bsem_pkg::SEM_W-1:0]    granted_in;
   logic                          wake_valid_in;
   logic [bsem_pkg::WAKE_W-1:0]   wake_id_in;
   logic                          upd_en;
   logic [SIW-1:0]                upd_idx;
   logic                          upd_in_use, upd_held;
   logic [PW-1:0]                 upd_head;
   logic [CW-1:0]                 upd_count;
   logic                          ring_we;

   assign in_range = (32'(req_sem_id) < NUM_SEMS);
   assign rd_sidx  = in_range ? req_sem_id[SIW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff    <= bsem_pkg::OP_GET;
         sidx_ff  <= '0;
         valid_ff <= 1'b0;
         req_ff   <= '0;
         mode_ff  <= '0;
      end else if (cmd.load) begin
         op_ff    <= bsem_pkg::op_type'(req_op);
         sidx_ff  <= rd_sidx;
         valid_ff <= in_range;
         req_ff   <= req_requester[EW-1:0];
         mode_ff  <= req_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         // oldest waiter, used only by signal
         rdata_ff <= ring_mem[{rd_sidx, head_ff[rd_sidx]}];
      end
      if (ring_we) begin
         ring_mem[{sidx_ff, tail}] <= req_ff;
      end
   end

   assign cur_in_use = in_use_ff[sidx_ff];
   assign cur_held   = held_ff[sidx_ff];
   assign cur_head   = head_ff[sidx_ff];
   assign cur_count  = count_ff[sidx_ff];

   // lowest free semaphore for get
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SEMS_USED - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SIW'(i);
         end
      end
   end

   // ring positions wrap at QUEUE_DEPTH
   assign tail_sum = (CW+1)'(cur_head) + (CW+1)'(cur_count);
   assign tail     = (32'(tail_sum) >= QUEUE_DEPTH)
                     ? PW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : PW'(tail_sum);
   assign head_inc  = (PW+1)'(cur_head) + (PW+1)'(1);
   assign head_next = (32'(head_inc) == QUEUE_DEPTH) ? '0 : PW'(head_inc);

   always_comb begin
      status_in     = bsem_pkg::ST_OK;
      granted_in    = '0;
      wake_valid_in = 1'b0;
      wake_id_in    = '0;
      upd_en        = 1'b0;
      upd_idx       = sidx_ff;
      upd_in_use    = cur_in_use;
      upd_held      = cur_held;
      upd_head      = cur_head;
      upd_count     = cur_count;
      ring_we       = 1'b0;
      unique case (op_ff)
         bsem_pkg::OP_GET: begin
            if (mode_ff > bsem_pkg::MODE_W'(1)) begin
               status_in = bsem_pkg::ST_BAD_MODE;
            end else if (!free_found) begin
               status_in = bsem_pkg::ST_NO_FREE;
            end else begin
               upd_en     = 1'b1;
               upd_idx    = free_idx;
               upd_in_use = 1'b1;
               upd_held   = mode_ff[0];
               upd_head   = '0;
               upd_count  = '0;
               granted_in = bsem_pkg::SEM_W'(free_idx);
            end
         end
         bsem_pkg::OP_FREE: begin
            if (valid_ff && cur_in_use) begin
               upd_en     = 1'b1;
               upd_in_use = 1'b0;
               upd_held   = 1'b0;
               upd_head   = '0;
               upd_count  = '0;
            end
         end
         bsem_pkg::OP_WAIT: begin
            priority if (!valid_ff) begin
               status_in = bsem_pkg::ST_NOT_HELD;
            end else if (!cur_held) begin
               upd_en   = 1'b1;
               upd_held = 1'b1;
            end else if (32'(cur_count) >= QUEUE_DEPTH) begin
               status_in = bsem_pkg::ST_QUEUE_FULL;
            end else begin
               upd_en    = 1'b1;
               upd_count = cur_count + CW'(1);
               ring_we   = cmd.commit;
               status_in = bsem_pkg::ST_BLOCK;
            end
         end
         bsem_pkg::OP_SIGNAL: begin
            priority if (!valid_ff || !cur_held) begin
               status_in = bsem_pkg::ST_NOT_HELD;
            end else if (cur_count != '0) begin
               // hand over: value stays 1 for the woken requester
               upd_en        = 1'b1;
               upd_head      = head_next;
               upd_count     = cur_count - CW'(1);
               wake_valid_in = 1'b1;
               wake_id_in    = bsem_pkg::WAKE_W'(rdata_ff);
            end else begin
               upd_en   = 1'b1;
               upd_held = 1'b0;
            end
         end
         default: status_in = bsem_pkg::ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SEMS_USED; i++) begin
            in_use_ff[i] <= 1'b0;
            held_ff[i]   <= 1'b0;
            head_ff[i]   <= '0;
            count_ff[i]  <= '0;
         end
      end else if (cmd.commit && upd_en) begin
         in_use_ff[upd_idx] <= upd_in_use;
         held_ff[upd_idx]   <= upd_held;
         head_ff[upd_idx]   <= upd_head;
         count_ff[upd_idx]  <= upd_count;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff     <= status_in;
         granted_ff    <= granted_in;
         wake_valid_ff <= wake_valid_in;
         wake_id_ff    <= wake_id_in;
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_granted_id = granted_ff;
   assign rsp_wake_valid = wake_valid_ff;
   assign rsp_wake_id    = wake_id_ff;

   // a semaphore at value 0 never has waiters
   a_idle_sem_no_waiters: assert property (@(posedge clock) disable iff (reset)
      !cur_held |-> (cur_count == '0))
      else $error("semaphore at value 0 has queued waiters");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cur_count) <= QUEUE_DEPTH)
      else $error("wait ring count beyond depth");

   a_wake_is_ok: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && wake_valid_in) |-> (status_in == bsem_pkg::ST_OK)
                                        && (op_ff == bsem_pkg::OP_SIGNAL))
      else $error("wake reported outside a successful signal");

   a_ring_write_then_count: assert property (@(posedge clock) disable iff (reset)
      ring_we |=> (count_ff[$past(sidx_ff)] == $past(cur_count) + CW'(1)))
      else $error("ring written without growing the waiter count");

endmodule

// ===== hw/rtl/binary_semaphore_table_with_fifo_waiters.sv =====
`timescale 1ns / 1ps
// Table of binary semaphores, each with a FIFO ring of waiting requester ids.
// A transaction passes from acceptance to the result register thus: the accept
// cycle reads the ring head of the addressed semaphore from the queue memory,
// then the execute state does the read-modify-write of the semaphore entry,
// writes the ring on a queued wait and loads the result. A new request is
// taken in the cycle after that, also while the previous result still waits
// on rsp_chan; the execute cycle holds only while the result register is
// still occupied. No clearing pass after reset: the table is ready at once.
// Depends on bsem_pkg, bsem_ifs, bsem_ctrl and bsem_dpath.

module binary_semaphore_table_with_fifo_waiters #(
   parameter int NUM_SEMS    = 16,
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8
) (
   input  logic              clock,
   input  logic              reset,
   bsem_req_if.sink          req_chan,
   bsem_rsp_if.source        rsp_chan
);

   bsem_pkg::cmd_type cmd;

   bsem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   bsem_dpath #(
      .NUM_SEMS    (NUM_SEMS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_op         (req_chan.op),
      .req_sem_id     (req_chan.sem_id),
      .req_requester  (req_chan.requester),
      .req_mode       (req_chan.mode),
      .rsp_status     (rsp_chan.status),
      .rsp_granted_id (rsp_chan.granted_id),
      .rsp_wake_valid (rsp_chan.wake_valid),
      .rsp_wake_id    (rsp_chan.wake_id)
   );

endmodule
